@@ rtl/eotd_pkg.sv @@
package eotd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;   // max square is 2^30
  localparam int SUM_W    = 43;
  localparam int POS_W    = 13;
  localparam int MS_W     = 16;
  localparam int FLEN_W   = 10;
  localparam int CFG_W    = 43;
  localparam int IDX_W    = 3;

  localparam logic [POS_W-1:0] FRAME_MAX = POS_W'(4096);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0] REG_FRAME_SAMPLES   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_LENGTH_MS = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MIN_SPEECH_MS   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_END_SILENCE_MS  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ENERGY_LIMIT    = IDX_W'(4);

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_WAIT  = 2'd1,
    VERDICT_REPLY = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [POS_W-1:0]  frame_len;     // already clamped to 1..FRAME_MAX
    logic [FLEN_W-1:0] step_ms;
    logic [MS_W-1:0]   min_speech;
    logic [MS_W-1:0]   end_silence;
    logic [SUM_W-1:0]  energy_limit;
  } cfg_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            restart;
  } entry_t;

  function automatic logic [MS_W-1:0] sat_add_ms(logic [MS_W-1:0] a,
                                                 logic [FLEN_W-1:0] b);
    logic [MS_W:0] s;
    s = {1'b0, a} + (MS_W+1)'(b);
    return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
  endfunction

endpackage

@@ rtl/eotd_if.sv @@
interface eotd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface eotd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] voiced_ms;
  logic [15:0] tail_silence_ms;
  logic [42:0] peak_energy;
  logic        frame_is_speech;
  logic [1:0]  verdict;

  modport source (output valid, output voiced_ms, output tail_silence_ms,
                  output peak_energy, output frame_is_speech, output verdict,
                  input ready);
  modport sink   (input valid, input voiced_ms, input tail_silence_ms,
                  input peak_energy, input frame_is_speech, input verdict,
                  output ready);
endinterface

@@ rtl/eotd_front.sv @@
module eotd_front (
  eotd_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push_valid,
  output eotd_pkg::entry_t push_data
);
  import eotd_pkg::*;

  logic signed [SAMPLE_W-1:0]   smp;
  logic signed [2*SAMPLE_W-1:0] prod;

  assign smp  = signed'(in_ch.sample);
  assign prod = smp * smp;

  // square lands in the queue register
  assign push_data.sq      = prod[SQ_W-1:0];
  assign push_data.restart = in_ch.restart;
  assign push_valid        = in_ch.valid;
  assign in_ch.ready       = !q_full;
endmodule

@@ rtl/eotd_queue.sv @@
module eotd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  eotd_pkg::entry_t push_data,
  output logic             full,
  output logic             pop_valid,
  output eotd_pkg::entry_t pop_data,
  input  logic             pop_ready
);
  import eotd_pkg::*;

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push, pop;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

@@ rtl/eotd_back.sv @@
module eotd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  eotd_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  eotd_pkg::entry_t q_data,
  output logic             q_ready,
  eotd_out_if.source       out_ch
);
  import eotd_pkg::*;

  // accumulate stage
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  logic             ev_restart_r, ev_done_r;
  logic [SUM_W-1:0] ev_sum_r;

  logic             pop;
  logic [SUM_W-1:0] base_sum, acc_sat;
  logic [SUM_W:0]   acc;
  logic [POS_W-1:0] base_pos, pos_inc;
  logic             acc_done;

  // decision stage
  logic [MS_W-1:0]  speech_r, speech_nxt;
  logic [MS_W-1:0]  sil_r, sil_nxt;
  logic [SUM_W-1:0] peak_r, peak_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MS_W-1:0]  o_speech_r, o_sil_r;
  logic [SUM_W-1:0] o_peak_r;
  logic             o_is_speech_r;
  verdict_t         o_verdict_r;

  logic             out_free, b_go;
  logic [MS_W-1:0]  sp_base, sil_base, sp_new, sil_new;
  logic [SUM_W-1:0] pk_base, clamped, pk_new;
  logic             is_speech;
  verdict_t         verdict;

  assign out_free = !out_valid_r || out_ch.ready;
  assign b_go     = ev_valid_r && (!ev_done_r || out_free);
  assign q_ready  = !ev_valid_r || b_go;
  assign pop      = q_valid && q_ready;

  always_comb begin
    base_sum = q_data.restart ? '0 : sum_r;
    base_pos = q_data.restart ? '0 : pos_r;
    acc      = {1'b0, base_sum} + (SUM_W+1)'(q_data.sq);
    acc_sat  = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
    pos_inc  = base_pos + POS_W'(1);
    acc_done = (pos_inc >= cfg.frame_len);

    sum_nxt = sum_r;
    pos_nxt = pos_r;
    if (pop) begin
      sum_nxt = acc_done ? '0 : acc_sat;
      pos_nxt = acc_done ? '0 : pos_inc;
    end

    if (pop) begin
      ev_valid_nxt = 1'b1;
    end else if (b_go) begin
      ev_valid_nxt = 1'b0;
    end else begin
      ev_valid_nxt = ev_valid_r;
    end
  end

  always_comb begin
    sp_base  = ev_restart_r ? '0 : speech_r;
    sil_base = ev_restart_r ? '0 : sil_r;
    pk_base  = ev_restart_r ? '0 : peak_r;

    is_speech = (ev_sum_r >= cfg.energy_limit);
    clamped   = is_speech ? cfg.energy_limit : ev_sum_r;
    pk_new    = (clamped > pk_base) ? clamped : pk_base;

    if (is_speech) begin
      sp_new  = sat_add_ms(sp_base, cfg.step_ms);
      sil_new = '0;
    end else begin
      sp_new  = sp_base;
      sil_new = (sp_base != '0) ? sat_add_ms(sil_base, cfg.step_ms) : sil_base;
    end

    if (sp_new < cfg.min_speech) begin
      verdict = VERDICT_NONE;
    end else if (sil_new >= cfg.end_silence) begin
      verdict = VERDICT_REPLY;
    end else begin
      verdict = VERDICT_WAIT;
    end

    speech_nxt = speech_r;
    sil_nxt    = sil_r;
    peak_nxt   = peak_r;
    if (b_go) begin
      if (ev_done_r && (verdict == VERDICT_REPLY)) begin
        speech_nxt = '0;
        sil_nxt    = '0;
        peak_nxt   = '0;
      end else if (ev_done_r) begin
        speech_nxt = sp_new;
        sil_nxt    = sil_new;
        peak_nxt   = pk_new;
      end else begin
        speech_nxt = sp_base;
        sil_nxt    = sil_base;
        peak_nxt   = pk_base;
      end
    end

    if (b_go && ev_done_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pos_r       <= '0;
      ev_valid_r  <= 1'b0;
      speech_r    <= '0;
      sil_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      ev_valid_r  <= ev_valid_nxt;
      speech_r    <= speech_nxt;
      sil_r       <= sil_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ev_restart_r <= q_data.restart;
      ev_done_r    <= acc_done;
      ev_sum_r     <= acc_sat;
    end
    if (b_go && ev_done_r) begin
      o_speech_r    <= sp_new;
      o_sil_r       <= sil_new;
      o_peak_r      <= pk_new;
      o_is_speech_r <= is_speech;
      o_verdict_r   <= verdict;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.voiced_ms       = o_speech_r;
  assign out_ch.tail_silence_ms = o_sil_r;
  assign out_ch.peak_energy     = o_peak_r;
  assign out_ch.frame_is_speech = o_is_speech_r;
  assign out_ch.verdict         = o_verdict_r;
endmodule

@@ rtl/energy_end_of_turn_detector_unit.sv @@
// Energy end-of-turn detector: frame energy VAD with speech/silence hangover.
// Throughput: one sample per cycle unless the output stalls; one result per
//   finished frame. A frame's last sample is registered in turn: square into
//   queue, accumulate stage, decision into output register.
// Reset: synchronous, active-low rst_n; clears queue, counters, frame sum and
//   peak, and loads the default register values. No clearing pass.
module energy_end_of_turn_detector_unit (
  input  logic              clk,
  input  logic              rst_n,
  eotd_in_if.sink           in_ch,
  eotd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [42:0]       cfg_data
);
  import eotd_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   push_valid;
  entry_t push_data;
  logic   q_full;
  logic   q_valid;
  entry_t q_data;
  logic   q_ready;

  logic [POS_W-1:0] fs_raw;

  // Register file. Frame length is clamped to 1..FRAME_MAX on write so the
  // accumulate stage compares against a ready value.
  always_comb begin
    fs_raw  = cfg_data[POS_W-1:0];
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_SAMPLES: begin
          if (fs_raw == '0) begin
            cfg_nxt.frame_len = POS_W'(1);
          end else if (fs_raw > FRAME_MAX) begin
            cfg_nxt.frame_len = FRAME_MAX;
          end else begin
            cfg_nxt.frame_len = fs_raw;
          end
        end
        REG_FRAME_LENGTH_MS: cfg_nxt.step_ms      = cfg_data[FLEN_W-1:0];
        REG_MIN_SPEECH_MS:   cfg_nxt.min_speech   = cfg_data[MS_W-1:0];
        REG_END_SILENCE_MS:  cfg_nxt.end_silence  = cfg_data[MS_W-1:0];
        REG_ENERGY_LIMIT:    cfg_nxt.energy_limit = cfg_data[SUM_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_len    <= POS_W'(160);
      cfg_r.step_ms      <= FLEN_W'(20);
      cfg_r.min_speech   <= MS_W'(180);
      cfg_r.end_silence  <= MS_W'(650);
      cfg_r.energy_limit <= SUM_W'(24738900);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: square each sample, tag restart, push into the queue.
  eotd_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Short queue decouples intake from the accumulate/decide pipeline.
  eotd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_ready)
  );

  // Back: frame accumulation, speech decision, hangover counters, output reg.
  eotd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );
endmodule

@@ rtl/eotd_checker.sv @@
module eotd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] voiced_ms,
  input logic [15:0] tail_silence_ms,
  input logic        frame_is_speech,
  input logic [1:0]  verdict
);
  import eotd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_speech_clears_silence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_is_speech |-> tail_silence_ms == '0)
    else $error("speech frame with nonzero trailing silence");

  a_silence_needs_speech: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && voiced_ms == '0 |-> tail_silence_ms == '0)
    else $error("trailing silence without prior speech");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (verdict == VERDICT_NONE || verdict == VERDICT_WAIT ||
                   verdict == VERDICT_REPLY))
    else $error("bad verdict code");
endmodule

bind energy_end_of_turn_detector_unit eotd_checker u_eotd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .voiced_ms       (out_ch.voiced_ms),
  .tail_silence_ms (out_ch.tail_silence_ms),
  .frame_is_speech (out_ch.frame_is_speech),
  .verdict         (out_ch.verdict)
);

@@ test/energy_end_of_turn_detector_unit_tb.sv @@
module energy_end_of_turn_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eotd_pkg::*;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [IDX_W-1:0] REG_SPARE_5 = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SPARE_7 = IDX_W'(7);

  localparam longint unsigned SUM_MAX   = (64'd1 << SUM_W) - 1;
  localparam longint unsigned LIMIT_TOP = 64'd1 << 42;  // exactly 4096 full-scale squares
  localparam longint unsigned MS_MAX    = 64'd65535;

  localparam int RANDOM_ITEMS   = 380;
  localparam int OVERSIZE_ITEMS = 40;
  localparam int DRAIN_PAD      = 6;     // margin past the block's pipeline
  localparam int STALL_LIMIT    = 2000;  // cycles with no request moving on either side

  typedef struct {
    logic [MS_W-1:0]  voiced_ms;
    logic [MS_W-1:0]  silence_ms;
    logic [SUM_W-1:0] peak;
    logic             is_speech;
    verdict_t         verdict;
  } frame_result_t;

  // Directed table: register writes, samples checked by the predictor, and
  // samples whose result is typed in by hand.
  typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [IDX_W-1:0]      idx;
    logic [CFG_W-1:0]      data;
    logic [SAMPLE_W-1:0]   sample;
    logic                  restart;
    frame_result_t         known;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  eotd_in_if  in_ch  ();
  eotd_out_if out_ch ();

  energy_end_of_turn_detector_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers, as last written.
  longint unsigned cfg_frame_samples;
  longint unsigned cfg_step_ms;
  longint unsigned cfg_min_speech;
  longint unsigned cfg_end_silence;
  longint unsigned cfg_energy_limit;

  // Predictor state.
  longint unsigned energy_sum;
  longint unsigned samples_in_frame;
  longint unsigned speech_total;
  longint unsigned silence_total;
  longint unsigned peak_seen;

  frame_result_t pending_frames[$];  // frame results still owed by the block
  stim_row_t     directed_rows[$];
  int            mismatches = 0;

  int send_idle_pct;   // chance the sender holds back a cycle
  int recv_stall_pct;  // chance the receiver drops ready

  // Random sample shaping: talk and pause bursts a few frames long.
  bit talking = 1'b0;
  int burst_left = 0;

  function automatic longint unsigned sat_ms(longint unsigned x);
    return (x > MS_MAX) ? MS_MAX : x;
  endfunction

  // Zero acts as one, anything past FRAME_MAX as FRAME_MAX.
  function automatic int frame_span();
    if (cfg_frame_samples == 0) return 1;
    if (cfg_frame_samples > longint'(FRAME_MAX)) return int'(FRAME_MAX);
    return int'(cfg_frame_samples);
  endfunction

  function automatic void clear_run_state();
    energy_sum       = 0;
    samples_in_frame = 0;
    speech_total     = 0;
    silence_total    = 0;
    peak_seen        = 0;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void apply_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_FRAME_SAMPLES:   cfg_frame_samples = data[POS_W-1:0];
      REG_FRAME_LENGTH_MS: cfg_step_ms       = data[FLEN_W-1:0];
      REG_MIN_SPEECH_MS:   cfg_min_speech    = data[MS_W-1:0];
      REG_END_SILENCE_MS:  cfg_end_silence   = data[MS_W-1:0];
      REG_ENERGY_LIMIT:    cfg_energy_limit  = data[SUM_W-1:0];
      default: ;
    endcase
  endfunction

  // One accepted sample: accumulate its square, close the frame when due.
  task automatic track_frame_energy(input logic [SAMPLE_W-1:0] smp, input logic rst,
                                    output bit finished, output frame_result_t res);
    longint          sv;
    longint unsigned sq;
    longint unsigned clamped;
    bit              loud;
    verdict_t        v;
    sv = $signed(smp);
    sq = sv * sv;
    finished = 1'b0;
    if (rst) clear_run_state();
    energy_sum += sq;
    if (energy_sum > SUM_MAX) energy_sum = SUM_MAX;
    samples_in_frame++;
    // a shrunk frame length closes the frame as soon as we are at or past it
    if (samples_in_frame < frame_span()) return;

    loud    = energy_sum >= cfg_energy_limit;
    clamped = loud ? cfg_energy_limit : energy_sum;
    if (clamped > peak_seen) peak_seen = clamped;
    if (loud) begin
      speech_total  = sat_ms(speech_total + cfg_step_ms);
      silence_total = 0;
    end else if (speech_total > 0) begin
      silence_total = sat_ms(silence_total + cfg_step_ms);
    end
    energy_sum       = 0;
    samples_in_frame = 0;

    if (speech_total < cfg_min_speech) v = VERDICT_NONE;
    else if (silence_total >= cfg_end_silence) v = VERDICT_REPLY;
    else v = VERDICT_WAIT;

    res.voiced_ms  = MS_W'(speech_total);
    res.silence_ms = MS_W'(silence_total);
    res.peak       = SUM_W'(peak_seen);
    res.is_speech  = loud;
    res.verdict    = v;
    finished       = 1'b1;
    // counters shown are pre-clear; the turn ends here
    if (v == VERDICT_REPLY) clear_run_state();
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_frame();
    frame_result_t got;
    frame_result_t want;
    got.voiced_ms  = out_ch.voiced_ms;
    got.silence_ms = out_ch.tail_silence_ms;
    got.peak       = out_ch.peak_energy;
    got.is_speech  = out_ch.frame_is_speech;
    got.verdict    = verdict_t'(out_ch.verdict);
    if (pending_frames.size() == 0) begin
      flag_mismatch("frame result with nothing expected");
      return;
    end
    want = pending_frames.pop_front();
    if (got.voiced_ms !== want.voiced_ms)
      flag_mismatch($sformatf("voiced_ms %0d, expected %0d", got.voiced_ms, want.voiced_ms));
    if (got.silence_ms !== want.silence_ms)
      flag_mismatch($sformatf("tail_silence_ms %0d, expected %0d",
                              got.silence_ms, want.silence_ms));
    if (got.peak !== want.peak)
      flag_mismatch($sformatf("peak_energy %0d, expected %0d", got.peak, want.peak));
    if (got.is_speech !== want.is_speech)
      flag_mismatch($sformatf("frame_is_speech %0b, expected %0b",
                              got.is_speech, want.is_speech));
    if (got.verdict !== want.verdict)
      flag_mismatch($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
  endtask

  // Results are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_frame();
  end

  // Receiver backpressure, changed on the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: the run is stuck if no request moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge once the sample is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic rst,
                             input bit use_known, input frame_result_t known);
    frame_result_t predicted;
    bit            finished;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= smp;
    in_ch.restart <= rst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_frame_energy(smp, rst, finished, predicted);
    if (finished)
      pending_frames.insert(pending_frames.size(), use_known ? known : predicted);
    @(negedge clk);
  endtask

  // Stop sending, let owed results out, then give a partial frame time to settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic longint unsigned scaled_ms(longint unsigned ms);
    return sat_ms(ms * $urandom_range(0, 6));
  endfunction

  // New settings for a random stretch; extremes show up now and then.
  task automatic random_setting();
    longint unsigned fs, ms, lo_speech, end_sil, lim;
    case ($urandom_range(0, 9))
      0:       fs = 0;
      1, 2, 3, 4, 5, 6: fs = $urandom_range(1, 4);
      7, 8:    fs = $urandom_range(5, 24);
      default: fs = 160;
    endcase
    cfg_write(REG_FRAME_SAMPLES, CFG_W'(fs));

    case ($urandom_range(0, 7))
      0:       ms = 0;
      1:       ms = 1000;
      2:       ms = 1023;
      default: ms = $urandom_range(1, 60);
    endcase
    cfg_write(REG_FRAME_LENGTH_MS, CFG_W'(ms));

    case ($urandom_range(0, 5))
      0:       lo_speech = 0;
      1:       lo_speech = MS_MAX;
      default: lo_speech = scaled_ms(ms);
    endcase
    cfg_write(REG_MIN_SPEECH_MS, CFG_W'(lo_speech));

    case ($urandom_range(0, 5))
      0:       end_sil = 0;
      1:       end_sil = MS_MAX;
      default: end_sil = scaled_ms(ms);
    endcase
    cfg_write(REG_END_SILENCE_MS, CFG_W'(end_sil));

    // Typical limit sits between a quiet frame (<= 2^20 per sample) and a
    // loud one (>= 2^26 per sample).
    case ($urandom_range(0, 7))
      0:       lim = 0;
      1:       lim = SUM_MAX;
      2:       lim = LIMIT_TOP;
      3:       lim = {$urandom(), $urandom()} & SUM_MAX;
      default: lim = longint'(frame_span()) << 24;
    endcase
    cfg_write(REG_ENERGY_LIMIT, CFG_W'(lim));

    if ($urandom_range(0, 3) == 0)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_5 : REG_SPARE_7,
                CFG_W'({$urandom(), $urandom()}));
  endtask

  task automatic random_sample(output logic [SAMPLE_W-1:0] smp, output logic rst);
    int amp;
    if (burst_left <= 0) begin
      talking    = !talking;
      burst_left = frame_span() * $urandom_range(1, 12);
    end
    burst_left--;
    if ($urandom_range(0, 9) == 0) begin
      smp = SAMPLE_W'($urandom());  // raw noise, any bit pattern
    end else begin
      amp = talking ? $urandom_range(8192, 32767) : $urandom_range(0, 1023);
      smp = $urandom_range(0, 1) ? SAMPLE_W'(-amp) : SAMPLE_W'(amp);
    end
    rst = ($urandom_range(0, 99) < 2);
  endtask

  function automatic stim_row_t write_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row.kind    = ROW_WRITE;
    row.idx     = idx;
    row.data    = data;
    row.sample  = '0;
    row.restart = 1'b0;
    row.known   = '{'0, '0, '0, 1'b0, VERDICT_NONE};
    return row;
  endfunction

  function automatic stim_row_t sample_row(logic [SAMPLE_W-1:0] smp, logic rst);
    stim_row_t row;
    row         = write_row(REG_FRAME_SAMPLES, '0);
    row.kind    = ROW_SAMPLE;
    row.sample  = smp;
    row.restart = rst;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [SAMPLE_W-1:0] smp, logic rst,
                                          frame_result_t res);
    stim_row_t row;
    row       = sample_row(smp, rst);
    row.kind  = ROW_KNOWN;
    row.known = res;
    return row;
  endfunction

  initial begin
    stim_row_t     row;
    logic [SAMPLE_W-1:0] smp;
    logic          rst;
    int            sent;
    int            burst;
    int            stage;

    // everything known from time zero
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;

    cfg_frame_samples = 160;
    cfg_step_ms       = 20;
    cfg_min_speech    = 180;
    cfg_end_silence   = 650;
    cfg_energy_limit  = 24738900;
    clear_run_state();

    send_idle_pct  = 14;
    recv_stall_pct = 60;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // partial frame under reset defaults, then shrink the frame under it
    add_row(sample_row(16'h8000, 1'b0));
    add_row(sample_row(16'h7FFF, 1'b0));
    add_row(write_row(REG_FRAME_SAMPLES, 43'd1));
    add_row(write_row(REG_FRAME_LENGTH_MS, 43'd1000));
    add_row(write_row(REG_MIN_SPEECH_MS, 43'd0));
    add_row(write_row(REG_END_SILENCE_MS, 43'd65535));
    // zero limit: every frame is speech, peak pinned at zero
    add_row(write_row(REG_ENERGY_LIMIT, 43'd0));
    add_row(known_row(16'h8000, 1'b1, '{16'd1000, 16'd0, 43'd0, 1'b1, VERDICT_WAIT}));
    add_row(known_row(16'h7FFF, 1'b0, '{16'd2000, 16'd0, 43'd0, 1'b1, VERDICT_WAIT}));
    // unreachable limit: silence after speech starts counting
    add_row(write_row(REG_ENERGY_LIMIT, CFG_W'(SUM_MAX)));
    add_row(known_row(16'h0000, 1'b0, '{16'd2000, 16'd1000, 43'd0, 1'b0, VERDICT_WAIT}));
    add_row(sample_row(16'h8000, 1'b0));
    add_row(write_row(REG_END_SILENCE_MS, 43'd3000));
    add_row(sample_row(16'h0001, 1'b0));   // silence hits the end, reply
    add_row(write_row(REG_MIN_SPEECH_MS, 43'd65535));
    add_row(sample_row(16'h7FFF, 1'b1));   // no speech yet
    add_row(write_row(REG_ENERGY_LIMIT, CFG_W'(LIMIT_TOP)));
    add_row(write_row(REG_MIN_SPEECH_MS, 43'd0));
    add_row(write_row(REG_END_SILENCE_MS, 43'd0));
    // both thresholds zero: reply on the first frame, even without speech
    add_row(known_row(16'h0001, 1'b1, '{16'd0, 16'd0, 43'd1, 1'b0, VERDICT_REPLY}));
    // frame of 4 cut down to 2 after three samples
    add_row(write_row(REG_FRAME_SAMPLES, 43'd4));
    add_row(sample_row(16'h1111, 1'b0));
    add_row(sample_row(16'h2222, 1'b0));
    add_row(sample_row(16'hEEEE, 1'b0));
    add_row(write_row(REG_FRAME_SAMPLES, 43'd2));
    add_row(sample_row(16'h0F0F, 1'b0));
    // zero frame length acts as one
    add_row(write_row(REG_FRAME_SAMPLES, 43'd0));
    add_row(sample_row(16'hFFFF, 1'b0));
    // restart in the middle of a frame, zero ms per frame
    add_row(write_row(REG_FRAME_SAMPLES, 43'd3));
    add_row(write_row(REG_ENERGY_LIMIT, 43'd0));
    add_row(write_row(REG_FRAME_LENGTH_MS, 43'd0));
    add_row(sample_row(16'h4000, 1'b0));
    add_row(sample_row(16'h4000, 1'b0));
    add_row(sample_row(16'h8000, 1'b1));
    add_row(sample_row(16'h5555, 1'b0));
    add_row(sample_row(16'hAAAA, 1'b0));
    // widest ms step; writes past the register list change nothing
    add_row(write_row(REG_FRAME_LENGTH_MS, 43'd1023));
    add_row(write_row(REG_SPARE_5, {CFG_W{1'b1}}));
    add_row(write_row(REG_SPARE_7, 43'h123));
    add_row(write_row(REG_FRAME_SAMPLES, 43'd1));
    add_row(sample_row(16'h7FFF, 1'b0));
    add_row(sample_row(16'h8001, 1'b0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WRITE:  cfg_write(row.idx, row.data);
        ROW_SAMPLE: send_sample(row.sample, row.restart, 1'b0, row.known);
        default:    send_sample(row.sample, row.restart, 1'b1, row.known);
      endcase
    end

    // --- random part: talk/pause bursts under changing settings ---
    // idling runs sender-light/receiver-heavy, then the reverse, then none
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setting();
      burst = $urandom_range(30, 80);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        stage = (sent * 3) / RANDOM_ITEMS;
        send_idle_pct  = (stage == 0) ? 14 : (stage == 1) ? 60 : 0;
        recv_stall_pct = (stage == 0) ? 60 : (stage == 1) ? 14 : 0;
        random_sample(smp, rst);
        send_sample(smp, rst, 1'b0, row.known);
        sent++;
      end
    end

    // Oversized frame length clamps to 4096, so a short run of full-scale
    // samples closes no frame; shrinking to one then closes it on the next.
    cfg_write(REG_FRAME_SAMPLES, {{(CFG_W-POS_W){1'b0}}, {POS_W{1'b1}}});
    cfg_write(REG_ENERGY_LIMIT, CFG_W'(LIMIT_TOP));
    cfg_write(REG_FRAME_LENGTH_MS, 43'd1000);
    for (int k = 0; k < OVERSIZE_ITEMS; k++)
      send_sample(16'h8000, (k == 0), 1'b0, row.known);
    cfg_write(REG_FRAME_SAMPLES, 43'd1);
    for (int k = 0; k < 8; k++) begin
      random_sample(smp, rst);
      send_sample(smp, rst, 1'b0, row.known);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
